>>> rtl/core/s256e_pkg.sv
package s256e_pkg;

	localparam int LimbW = 64;
	localparam int NumLimbs = 4;
	localparam int KeyW = 256;

	localparam logic [KeyW-1:0] PrimeP =
		256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEFFFFFC2F;
	localparam logic [KeyW-1:0] Beta =
		256'h7ae96a2b657c07106e64479eac3434e99cf0497512f58995c1396c28719501ee;
	// beta^2 mod p, the other nontrivial cube root of unity
	localparam logic [KeyW-1:0] Beta2 =
		256'h851695d49a83f8ef919bb86153cbcb16630fb68aed0a766a3ec693d68e6afa40;

	localparam logic [1:0] PrefixEven = 2'd2;
	localparam logic [1:0] PrefixOdd  = 2'd3;
	localparam logic [2:0] LastPoint  = 3'd5;

	typedef struct packed {
		logic [LimbW-1:0] x_limb;
		logic             y_odd;
		logic             last_limb;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       point_index;
		logic [1:0]       prefix;
		logic [1:0]       limb_index;
		logic [LimbW-1:0] out_limb;
		logic             last_of_key;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic sel_beta2;
	} mul_cmd_t;

endpackage

>>> rtl/core/s256e_modmul.sv
// Constant-by-variable modular multiply, bit serial MSB first:
// acc = 2*acc + bit*x mod p, one bit of the constant a cycle.
module s256e_modmul (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  s256e_pkg::mul_cmd_t                       cmd,
	input  logic [s256e_pkg::KeyW-1:0]                x,
	output logic                                      done,
	output logic [s256e_pkg::KeyW-1:0]                result
);
	import s256e_pkg::*;

	logic             busy_q;
	logic [7:0]       bit_q;
	logic [KeyW-1:0]  k_q;
	logic [KeyW-1:0]  acc_q;
	logic [KeyW:0]    dbl;
	logic [KeyW-1:0]  dbl_r;
	logic [KeyW:0]    add;
	logic [KeyW-1:0]  add_r;

	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, PrimeP}) ? KeyW'(dbl - {1'b0, PrimeP}) : dbl[KeyW-1:0];
		add = {1'b0, dbl_r} + {1'b0, (k_q[KeyW-1] ? x : '0)};
		add_r = (add >= {1'b0, PrimeP}) ? KeyW'(add - {1'b0, PrimeP}) : add[KeyW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				bit_q <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + 8'd1;
				if (bit_q == 8'hFF) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
			k_q <= cmd.sel_beta2 ? Beta2 : Beta;
		end else if (busy_q) begin
			acc_q <= add_r;
			k_q <= {k_q[KeyW-2:0], 1'b0};
		end
	end

	assign result = acc_q;

`ifndef NO_ASSERTIONS
	// x is reduced before a multiply starts, so the accumulator stays reduced
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> acc_q < PrimeP) else $error("accumulator not reduced");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q) else $error("done while busy");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q) else $error("start while busy");
`endif
endmodule

>>> rtl/core/secp256k1_endomorphism_points.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_data  (s256e_pkg::in_item_t)
// out     | output    | out_valid / out_ready  | out_data (s256e_pkg::out_item_t)
//
// A limb without the last mark is stored and advances the limb count. The last
// limb starts a key: x is reduced, then two bit-serial multiplies of 256 bit
// steps each run in the shared modular multiplier, then 24 result transactions
// follow. Input is not ready from the last limb until the final result is
// loaded into the output register.
// arst_n clears the sequencer and limb count; limb storage is not cleared.
// The output register holds its transaction through any out_ready stall.
module secp256k1_endomorphism_points (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  s256e_pkg::in_item_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output s256e_pkg::out_item_t  out_data
);
	import s256e_pkg::*;

	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StReduce = 3'd1;
	localparam logic [2:0] StMul1   = 3'd2;
	localparam logic [2:0] StMul2   = 3'd3;
	localparam logic [2:0] StEmit   = 3'd4;

	logic [2:0]        state_q;
	logic [1:0]        limb_count_q;
	logic [LimbW-1:0]  x_store_q [NumLimbs];
	logic              odd_q;
	logic [KeyW-1:0]   x_q, x1_q, x2_q;
	logic [2:0]        pt_q;
	logic [1:0]        li_q;
	mul_cmd_t          cmd;
	logic              mul_done;
	logic [KeyW-1:0]   mul_res;
	logic [KeyW-1:0]   raw_x;
	logic [KeyW-1:0]   cur;
	logic              in_acc;
	logic              load_out;

	assign in_ready = (state_q == StIdle);
	assign in_acc = in_valid && in_ready;
	assign raw_x = {x_store_q[0], x_store_q[1], x_store_q[2], x_store_q[3]};

	s256e_modmul u_mul (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .x(x_q),
		.done(mul_done), .result(mul_res)
	);

	always_comb begin
		cmd.start = 1'b0;
		cmd.sel_beta2 = 1'b0;
		if (state_q == StReduce) begin
			cmd.start = 1'b1;
		end else if (state_q == StMul1 && mul_done) begin
			cmd.start = 1'b1;
			cmd.sel_beta2 = 1'b1;
		end
		case (pt_q[2:1])
			2'd0:    cur = x_q;
			2'd1:    cur = x1_q;
			default: cur = x2_q;
		endcase
		load_out = (state_q == StEmit) && (!out_valid || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			limb_count_q <= '0;
			pt_q <= '0;
			li_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load_out) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				StIdle: begin
					if (in_acc) begin
						if (in_data.last_limb) begin
							limb_count_q <= '0;
							state_q <= StReduce;
						end else begin
							limb_count_q <= limb_count_q + 2'd1;
						end
					end
				end
				StReduce: state_q <= StMul1;
				StMul1:   if (mul_done) state_q <= StMul2;
				StMul2: begin
					if (mul_done) begin
						state_q <= StEmit;
						pt_q <= '0;
						li_q <= '0;
					end
				end
				StEmit: begin
					if (load_out) begin
						li_q <= li_q + 2'd1;
						if (li_q == 2'd3) begin
							pt_q <= pt_q + 3'd1;
							if (pt_q == LastPoint) state_q <= StIdle;
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_store_q[limb_count_q] <= in_data.x_limb;
			if (in_data.last_limb) odd_q <= in_data.y_odd;
		end
		if (state_q == StReduce)
			x_q <= (raw_x >= PrimeP) ? raw_x - PrimeP : raw_x;
		if (state_q == StMul1 && mul_done) x1_q <= mul_res;
		if (state_q == StMul2 && mul_done) x2_q <= mul_res;
		if (load_out) begin
			out_data.point_index <= pt_q;
			out_data.prefix <= (pt_q[0] ^ odd_q) ? PrefixOdd : PrefixEven;
			out_data.limb_index <= li_q;
			out_data.out_limb <= cur[KeyW-1-{li_q, 6'd0} -: LimbW];
			out_data.last_of_key <= (pt_q == LastPoint) && (li_q == 2'd3);
		end
	end

`ifndef NO_ASSERTIONS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != StIdle |-> !in_ready) else $error("ready while busy");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.point_index <= LastPoint) else $error("bad point index");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_of_key |-> out_data.limb_index == 2'd3)
		else $error("last flag off final limb");
`endif
endmodule

>>> tb/sv/tb_top.sv
module tb_top;
	import s256e_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	secp256k1_endomorphism_points DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	typedef struct {
		in_item_t item;
		bit       zero_x;
	} row_t;

	out_item_t point_queue[$];
	logic [LimbW-1:0] limb_slot[NumLimbs];
	logic [1:0] slot_ptr = '0;
	logic [KeyW-1:0] beta_sq;
	int fail_count = 0;
	int keys_sent = 0;
	int items_sent = 0;
	int results_seen = 0;
	int long_holds = 0;
	bit stim_done = 1'b0;

	function automatic logic [KeyW-1:0] mod_mul(input logic [KeyW-1:0] a,
			input logic [KeyW-1:0] b);
		logic [2*KeyW-1:0] prod;
		logic [2*KeyW-1:0] modulus;
		prod = {{KeyW{1'b0}}, a} * {{KeyW{1'b0}}, b};
		modulus = {{KeyW{1'b0}}, PrimeP};
		prod = prod % modulus;
		return prod[KeyW-1:0];
	endfunction

	function automatic logic [LimbW-1:0] limb_at(input logic [KeyW-1:0] v, input int k);
		return v[KeyW-1-LimbW*k -: LimbW];
	endfunction

	// Update the limb store; on the last limb queue all 24 expected transactions.
	task automatic predict_points(input in_item_t it, input bit zero_x);
		logic [KeyW-1:0] x;
		logic [KeyW-1:0] pts[3];
		out_item_t o;
		limb_slot[slot_ptr] = it.x_limb;
		if (!it.last_limb) begin
			slot_ptr = slot_ptr + 2'd1;
			return;
		end
		slot_ptr = '0;
		keys_sent++;
		x = {limb_slot[0], limb_slot[1], limb_slot[2], limb_slot[3]};
		if (x >= PrimeP)
			x = x - PrimeP;
		pts[0] = x;
		pts[1] = mod_mul(Beta, x);
		pts[2] = mod_mul(beta_sq, x);
		for (int k = 0; k < 6; k++) begin
			for (int l = 0; l < NumLimbs; l++) begin
				o.point_index = 3'(k);
				o.prefix = ((k % 2) == 1) ^ it.y_odd ? PrefixOdd : PrefixEven;
				o.limb_index = 2'(l);
				o.out_limb = zero_x ? '0 : limb_at(pts[k/2], l);
				o.last_of_key = (3'(k) == LastPoint) && (l == NumLimbs - 1);
				point_queue.push_back(o);
			end
		end
	endtask

	task automatic send_limb(input in_item_t it, input bit zero_x);
		int gap;
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			(($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		items_sent++;
		predict_points(it, zero_x);
	endtask

	function automatic logic [LimbW-1:0] rand_limb();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_key(input int n_limbs);
		in_item_t it;
		bit big;
		big = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < n_limbs; i++) begin
			it.x_limb = (big && i < 3) ? '1 : rand_limb();
			it.y_odd = 1'($urandom);
			it.last_limb = (i == n_limbs - 1);
			send_limb(it, 1'b0);
		end
	endtask

	row_t directed[] = '{
		// x = 0, expect all-zero limbs
		'{'{64'h0, 1'b0, 1'b0}, 1'b0}, '{'{64'h0, 1'b0, 1'b0}, 1'b0},
		'{'{64'h0, 1'b0, 1'b0}, 1'b0}, '{'{64'h0, 1'b0, 1'b1}, 1'b1},
		// x = p - 1
		'{'{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0}, 1'b0},
		'{'{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0}, 1'b0},
		'{'{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0}, 1'b0},
		'{'{64'hFFFFFFFEFFFFFC2E, 1'b1, 1'b1}, 1'b0},
		// x = p reduces to zero
		'{'{64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b0}, 1'b0},
		'{'{64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b0}, 1'b0},
		'{'{64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b0}, 1'b0},
		'{'{64'hFFFFFFFEFFFFFC2F, 1'b1, 1'b1}, 1'b1},
		// all ones, above p
		'{'{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0}, 1'b0},
		'{'{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0}, 1'b0},
		'{'{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0}, 1'b0},
		'{'{64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b1}, 1'b0},
		// early last mark on the second limb
		'{'{64'h0123456789ABCDEF, 1'b1, 1'b0}, 1'b0},
		'{'{64'hFEDCBA9876543210, 1'b0, 1'b1}, 1'b0},
		// five limbs: the fifth wraps onto slot 0
		'{'{64'hAAAAAAAAAAAAAAAA, 1'b0, 1'b0}, 1'b0},
		'{'{64'h5555555555555555, 1'b0, 1'b0}, 1'b0},
		'{'{64'h8000000000000001, 1'b0, 1'b0}, 1'b0},
		'{'{64'h7FFFFFFFFFFFFFFE, 1'b0, 1'b0}, 1'b0},
		'{'{64'h00000000DEADBEEF, 1'b1, 1'b1}, 1'b0}
	};

	initial begin
		beta_sq = mod_mul(Beta, Beta);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_limb(directed[i].item, directed[i].zero_x);
		while (items_sent < 150) begin
			case ($urandom_range(0, 9))
				0: send_key($urandom_range(1, 3));
				1: send_key($urandom_range(5, 7));
				default: send_key(4);
			endcase
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: random stalls, plus one long hold-off while keys keep coming.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (long_holds == 0 && results_seen >= 40) begin
				long_holds++;
				out_ready <= 1'b0;
				repeat (1500) @(posedge clk);
			end
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 5);
			if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat (n * 3) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (point_queue.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected transaction: pt %0d limb %0d data %h",
						out_data.point_index, out_data.limb_index, out_data.out_limb);
			end else begin
				want = point_queue.pop_front();
				if (out_data.point_index !== want.point_index || out_data.prefix !== want.prefix
						|| out_data.limb_index !== want.limb_index
						|| out_data.out_limb !== want.out_limb
						|| out_data.last_of_key !== want.last_of_key) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"wrong transaction: exp pt %0d pre %0d limb %0d %h last %0b,",
							" got pt %0d pre %0d limb %0d %h last %0b"},
							want.point_index, want.prefix, want.limb_index, want.out_limb,
							want.last_of_key, out_data.point_index, out_data.prefix,
							out_data.limb_index, out_data.out_limb, out_data.last_of_key);
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		while (point_queue.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		$display("%0d limbs, %0d keys, %0d point limbs checked, %0d long output stall(s)",
			items_sent, keys_sent, results_seen, long_holds);
		if (fail_count == 0 && point_queue.size() == 0)
			$display("secp256k1_endomorphism_points: match");
		else
			$display("secp256k1_endomorphism_points: mismatch");
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout with %0d transactions outstanding", point_queue.size());
		$display("secp256k1_endomorphism_points: mismatch");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/s256e_pkg.sv
rtl/core/s256e_modmul.sv
rtl/core/secp256k1_endomorphism_points.sv
tb/sv/tb_top.sv
